// File: rtl/urs_pkg.sv
// Shared types and constants for the ultrasonic range sequencer.
`default_nettype none
package urs_pkg;

  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] CFG_PERIOD  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PULSE   = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE   = 8'd3;

  localparam logic [23:0] PERIOD_RESET  = 24'd500000;
  localparam logic [15:0] PULSE_RESET   = 16'd1000;
  localparam logic [23:0] TIMEOUT_RESET = 24'd2000000;
  localparam logic [15:0] SCALE_RESET   = 16'd1114;

  localparam logic [23:0] ECHO_MAX = 24'hFFFFFF;
  localparam logic [31:0] DIST_MAX = 32'hFFFFFFFF;

  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_PULSE = 2'd1;
  localparam logic [1:0] PH_WAIT  = 2'd2;

  typedef struct packed {
    logic [23:0] period_ticks;
    logic [15:0] pulse_ticks;
    logic [23:0] timeout_ticks;
    logic [15:0] scale;
  } cfg_t;

  typedef struct packed {
    logic        trig_level;
    logic        measure_done;
    logic        sensor_fault;
    logic [23:0] echo_ticks;
    logic [31:0] distance_q8;
  } res_t;

endpackage
`default_nettype wire

// File: rtl/urs_cfg_regs.sv
// Configuration register file for the ultrasonic range sequencer.
`default_nettype none
module urs_cfg_regs (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [urs_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [urs_pkg::CFG_DATA_W-1:0]   cfg_data,
  output urs_pkg::cfg_t                         cfg
);
  import urs_pkg::*;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.period_ticks  <= PERIOD_RESET;
      cfg.pulse_ticks   <= PULSE_RESET;
      cfg.timeout_ticks <= TIMEOUT_RESET;
      cfg.scale         <= SCALE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_PERIOD:  cfg.period_ticks  <= cfg_data[23:0];
        CFG_PULSE:   cfg.pulse_ticks   <= cfg_data[15:0];
        CFG_TIMEOUT: cfg.timeout_ticks <= cfg_data[23:0];
        CFG_SCALE:   cfg.scale         <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

// File: rtl/urs_core.sv
// Sequencer state, phase control and distance calculation for one tick.
`default_nettype none
module urs_core #(
  parameter int COUNT_WIDTH = 24
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          step,
  input  wire logic          echo_level,
  input  wire urs_pkg::cfg_t cfg,
  output urs_pkg::res_t      res
);
  import urs_pkg::*;

  localparam int CW = COUNT_WIDTH;
  localparam logic [CW-1:0] CNT_MAX = {CW{1'b1}};

  function automatic logic [CW-1:0] sat_inc(input logic [CW-1:0] v);
    return (v == CNT_MAX) ? v : v + 1'b1;
  endfunction

  logic [1:0]    phase, phase_next;
  logic [CW-1:0] period_count, period_count_next;
  logic [CW-1:0] phase_count, phase_count_next;
  logic [CW-1:0] echo_count, echo_count_next;
  logic          echo_counting, echo_counting_next;
  logic          echo_prev;
  logic          fault_flag, fault_flag_next;
  logic [23:0]   last_echo, last_echo_next;
  logic [31:0]   last_distance, last_distance_next;

  logic          rise, fall, done;
  logic [CW-1:0] pc_inc, ec_inc, per_inc;
  logic [CW+15:0] prod;
  logic [63:0]   dist_wide, echo_wide;

  assign rise    = echo_level && !echo_prev;
  assign fall    = !echo_level && echo_prev;
  assign pc_inc  = sat_inc(phase_count);
  assign ec_inc  = sat_inc(echo_count);
  assign per_inc = sat_inc(period_count);
  assign prod      = ec_inc * cfg.scale;
  assign dist_wide = 64'(prod[CW+15:8]);
  assign echo_wide = 64'(ec_inc);

  always_comb begin
    phase_next         = phase;
    phase_count_next   = phase_count;
    echo_count_next    = echo_count;
    echo_counting_next = echo_counting;
    fault_flag_next    = fault_flag;
    last_echo_next     = last_echo;
    last_distance_next = last_distance;
    period_count_next  = per_inc;
    done               = 1'b0;

    unique case (phase)
      PH_PULSE: begin
        phase_count_next = pc_inc;
        if (32'(pc_inc) >= 32'(cfg.pulse_ticks)) begin
          phase_next         = PH_WAIT;
          phase_count_next   = '0;
          echo_count_next    = '0;
          echo_counting_next = 1'b0;
        end
      end
      PH_WAIT: begin
        phase_count_next = pc_inc;
        if (rise) begin
          echo_count_next    = '0;
          echo_counting_next = 1'b1;
        end else if (echo_counting) begin
          echo_count_next = ec_inc;
        end
        if (fall && echo_counting) begin
          last_echo_next     = (echo_wide > 64'(ECHO_MAX)) ? ECHO_MAX : echo_wide[23:0];
          last_distance_next = (dist_wide > 64'(DIST_MAX)) ? DIST_MAX : dist_wide[31:0];
          fault_flag_next    = 1'b0;
          echo_counting_next = 1'b0;
          phase_next         = PH_IDLE;
          phase_count_next   = '0;
          done               = 1'b1;
        end else if (32'(pc_inc) >= 32'(cfg.timeout_ticks)) begin
          fault_flag_next    = 1'b1;
          echo_counting_next = 1'b0;
          phase_next         = PH_IDLE;
          phase_count_next   = '0;
        end
      end
      default: phase_next = PH_IDLE;
    endcase

    if (32'(per_inc) >= 32'(cfg.period_ticks)) begin
      period_count_next = '0;
      if (phase_next == PH_IDLE) begin
        phase_next       = PH_PULSE;
        phase_count_next = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      period_count  <= '0;
      phase_count   <= '0;
      echo_count    <= '0;
      echo_counting <= 1'b0;
      echo_prev     <= 1'b0;
      fault_flag    <= 1'b0;
      last_echo     <= '0;
      last_distance <= '0;
    end else if (step) begin
      phase         <= phase_next;
      period_count  <= period_count_next;
      phase_count   <= phase_count_next;
      echo_count    <= echo_count_next;
      echo_counting <= echo_counting_next;
      echo_prev     <= echo_level;
      fault_flag    <= fault_flag_next;
      last_echo     <= last_echo_next;
      last_distance <= last_distance_next;
    end
  end

  always_comb begin
    res.trig_level   = (phase_next == PH_PULSE);
    res.measure_done = done;
    res.sensor_fault = fault_flag_next;
    res.echo_ticks   = last_echo_next;
    res.distance_q8  = last_distance_next;
  end

endmodule
`default_nettype wire

// File: rtl/ultrasonic_range_sequencer.sv
// Ultrasonic range sequencer top level: input register, core, result register.
// Throughput: one request per cycle while out_stall does not hold the result register;
// the tick is registered, then one pass of counter update and the COUNT_WIDTH x 16
// distance multiply feeds the result register.
// Reset: rst is synchronous active high; it empties both stages, clears all
// counters and flags and restores the configuration registers to their defaults.
`default_nettype none
module ultrasonic_range_sequencer #(
  parameter int COUNT_WIDTH = 24
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic                            echo_level,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic                                 trig_level,
  output logic                                 measure_done,
  output logic                                 sensor_fault,
  output logic [23:0]                          echo_ticks,
  output logic [31:0]                          distance_q8,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [urs_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [urs_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import urs_pkg::*;

  cfg_t cfg;
  res_t core_res;
  res_t out_res;

  logic s1_valid;
  logic s1_echo;
  logic out_free;
  logic in_take;
  logic s1_take;

  assign out_free = !out_valid || !out_stall;
  assign in_stall = s1_valid && !out_free;
  assign in_take  = in_valid && !in_stall;
  assign s1_take  = s1_valid && out_free;

  urs_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  urs_core #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .step       (s1_take),
    .echo_level (s1_echo),
    .cfg        (cfg),
    .res        (core_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_take) begin
      s1_valid <= 1'b1;
    end else if (s1_take) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_echo <= echo_level;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_take) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_take) begin
      out_res <= core_res;
    end
  end

  assign trig_level   = out_res.trig_level;
  assign measure_done = out_res.measure_done;
  assign sensor_fault = out_res.sensor_fault;
  assign echo_ticks   = out_res.echo_ticks;
  assign distance_q8  = out_res.distance_q8;

  a_stall_needs_held: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (s1_valid && out_valid && out_stall))
    else $error("input stalled without a blocked request in flight");

  a_held_request_stays: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !out_free) |=> s1_valid)
    else $error("pending request lost while result register blocked");

  a_take_fills_out: assert property (@(posedge clk) disable iff (rst)
    s1_take |=> out_valid)
    else $error("consumed request produced no result");

  a_done_clears_fault: assert property (@(posedge clk) disable iff (rst)
    (out_valid && measure_done) |-> !sensor_fault)
    else $error("completed measurement shows fault");

endmodule
`default_nettype wire
